// ===== rtl/core/pure_pursuit_target_steer_assert.svh =====
// assertion macros for the core modules, included by ppts_back
`ifndef PURE_PURSUIT_TARGET_STEER_ASSERT_SVH
`define PURE_PURSUIT_TARGET_STEER_ASSERT_SVH

// same-cycle implication, needs i_clk and i_rst_n in scope
`define PPTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PPTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ppts_pkg.sv =====
`timescale 1ns / 1ps
package ppts_pkg;

    typedef struct packed {
        logic [15:0] lookahead;
        logic [14:0] gentle_thr;
        logic [14:0] sharp_thr;
        logic [14:0] steer_lim;
        logic [15:0] straight_spd;
        logic [15:0] gentle_spd;
        logic [15:0] sharp_spd;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_LOOKAHEAD    = 3'd0,
        REG_GENTLE_THR   = 3'd1,
        REG_SHARP_THR    = 3'd2,
        REG_STEER_LIM    = 3'd3,
        REG_STRAIGHT_SPD = 3'd4,
        REG_GENTLE_SPD   = 3'd5,
        REG_SHARP_SPD    = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQR,
        S_RINIT,
        S_ROOT,
        S_DEV,
        S_END,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

endpackage

// ===== rtl/core/ppts_if.sv =====
`timescale 1ns / 1ps
interface ppts_in_if #(parameter int CW = 24) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 last_point;

    modport source(output valid, point_x, point_y, last_point, input ready);
    modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface ppts_out_if #(parameter int IW = 12) ();
    logic              valid;
    logic              ready;
    logic signed [15:0] steer_cmd;
    logic [15:0]       drive_speed;
    logic [IW-1:0]     target_index;

    modport source(output valid, steer_cmd, drive_speed, target_index, input ready);
    modport sink(input valid, steer_cmd, drive_speed, target_index, output ready);
endinterface

// ===== rtl/core/ppts_front.sv =====
`timescale 1ns / 1ps
module ppts_front #(
    parameter int MAX_POINTS = 4096,
    parameter int CW         = 24,
    parameter int IW         = 12,
    parameter int W          = 3 + IW + 2 * CW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppts_in_if.sink      i_pt,
    input  logic         i_full,
    output logic         o_push,
    output logic [W-1:0] o_data
);
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] n_cnt;
    logic            inrng;
    logic            cand;

    assign i_pt.ready = !i_full;
    assign o_push     = i_pt.valid && !i_full;
    assign inrng      = r_cnt < CNTW'(MAX_POINTS);
    assign cand       = inrng && !i_pt.point_x[CW-1];
    assign o_data     = {i_pt.last_point, inrng, cand, r_cnt[IW-1:0],
                         i_pt.point_x, i_pt.point_y};

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_pt.last_point) begin
                n_cnt = '0;
            end else if (inrng) begin
                n_cnt = r_cnt + CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end
endmodule

// ===== rtl/core/ppts_fifo.sv =====
`timescale 1ns / 1ps
module ppts_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic [1:0]   r_cnt;
    logic         r_wp;
    logic         r_rp;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ===== rtl/core/ppts_back.sv =====
`timescale 1ns / 1ps
module ppts_back #(
    parameter int CW   = 24,
    parameter int IW   = 12,
    parameter int FB   = 12,
    parameter int W    = 3 + IW + 2 * CW
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppts_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  logic [W-1:0]   i_data,
    output logic           o_pop,
    ppts_out_if.source     o_res
);
    import ppts_pkg::*;
    `include "pure_pursuit_target_steer_assert.svh"

    localparam int SW   = 2 * CW;
    localparam int DVW  = ((CW > 16) ? CW : 16) + 1;
    localparam int NUMW = CW + 1 + 2 * FB;
    localparam int DCW  = $clog2(NUMW + 1);

    t_state r_state;
    t_state n_state;

    logic signed [CW-1:0] r_y;
    logic [CW-1:0]        r_xm;
    logic [CW-1:0]        r_ym;
    logic [IW-1:0]        r_idx;
    logic                 r_last;
    logic [SW-1:0]        r_xsq;
    logic [SW-1:0]        r_ysq;
    logic [SW-1:0]        r_rad;
    logic [CW+1:0]        r_rem;
    logic [CW-1:0]        r_root;
    logic [DCW-1:0]       r_cnt;
    logic [DVW-1:0]       r_best;
    logic [IW-1:0]        r_pbi;
    logic signed [CW-1:0] r_pby;
    logic                 r_found;
    logic [IW-1:0]        r_held_idx;
    logic signed [CW-1:0] r_held_y;
    logic [NUMW-1:0]      r_num;
    logic [NUMW-1:0]      r_q;
    logic [32:0]          r_r;
    logic [31:0]          r_den;
    logic                 r_inf;
    logic                 r_ovalid;
    logic signed [15:0]   r_steer;
    logic [15:0]          r_speed;
    logic [IW-1:0]        r_tidx;

    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic [IW-1:0]        in_idx;
    logic                 in_cand;
    logic                 in_rng;
    logic                 in_last;
    logic [CW+1:0]        rem_nx;
    logic [CW+1:0]        trial;
    logic [DVW-1:0]       d_ext;
    logic [DVW-1:0]       l_ext;
    logic [DVW-1:0]       dev;
    logic [32:0]          rr;
    logic [CW-1:0]        hy_mag;
    logic                 big;
    logic [14:0]          m15;
    logic [14:0]          mc;
    logic                 load;

    assign in_y    = i_data[CW-1:0];
    assign in_x    = i_data[2*CW-1:CW];
    assign in_idx  = i_data[2*CW+IW-1:2*CW];
    assign in_cand = i_data[2*CW+IW];
    assign in_rng  = i_data[2*CW+IW+1];
    assign in_last = i_data[2*CW+IW+2];

    assign o_pop   = (r_state == S_IDLE) && i_valid;
    assign rem_nx  = {r_rem[CW-1:0], r_rad[SW-1:SW-2]};
    assign trial   = {r_root, 2'b01};
    assign d_ext   = DVW'(r_root);
    assign l_ext   = DVW'(i_cfg.lookahead);
    assign dev     = (d_ext >= l_ext) ? d_ext - l_ext : l_ext - d_ext;
    assign rr      = {r_r[31:0], r_num[NUMW-1]};
    assign hy_mag  = r_held_y[CW-1] ? CW'(-r_held_y) : CW'(r_held_y);
    assign big     = r_inf || (|r_q[NUMW-1:15]);
    assign m15     = r_q[14:0];
    assign mc      = (big || m15 > i_cfg.steer_lim) ? i_cfg.steer_lim : m15;
    assign load    = (r_state == S_FIN) && (!r_ovalid || o_res.ready);

    assign o_res.valid          = r_ovalid;
    assign o_res.steer_cmd      = r_steer;
    assign o_res.drive_speed    = r_speed;
    assign o_res.target_index   = r_tidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (in_cand) begin
                        n_state = S_SQR;
                    end else if (in_last) begin
                        n_state = S_END;
                    end
                end
            end
            S_SQR:   n_state = S_RINIT;
            S_RINIT: n_state = S_ROOT;
            S_ROOT: begin
                if (r_cnt == DCW'(1)) begin
                    n_state = S_DEV;
                end
            end
            S_DEV:   n_state = r_last ? S_END : S_IDLE;
            S_END:   n_state = S_PREP;
            S_PREP: begin
                if (hy_mag == '0 || i_cfg.lookahead == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == DCW'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_y    <= in_y;
                r_xm   <= in_x;
                r_ym   <= in_y[CW-1] ? CW'(-in_y) : CW'(in_y);
                r_idx  <= in_idx;
                r_last <= in_last;
            end
            S_SQR: begin
                r_xsq <= SW'(r_xm) * SW'(r_xm);
                r_ysq <= SW'(r_ym) * SW'(r_ym);
            end
            S_RINIT: begin
                r_rad  <= r_xsq + r_ysq;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= DCW'(CW);
            end
            S_ROOT: begin
                r_rad <= {r_rad[SW-3:0], 2'b00};
                r_cnt <= r_cnt - DCW'(1);
                if (rem_nx >= trial) begin
                    r_rem  <= rem_nx - trial;
                    r_root <= {r_root[CW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_nx;
                    r_root <= {r_root[CW-2:0], 1'b0};
                end
            end
            S_PREP: begin
                r_num <= NUMW'(hy_mag) << (1 + 2 * FB);
                r_den <= 32'(i_cfg.lookahead) * 32'(i_cfg.lookahead);
                r_q   <= '0;
                r_r   <= '0;
                r_cnt <= DCW'(NUMW);
                r_inf <= (hy_mag != '0) && (i_cfg.lookahead == '0);
            end
            S_DIV: begin
                r_num <= {r_num[NUMW-2:0], 1'b0};
                r_cnt <= r_cnt - DCW'(1);
                if (rr >= {1'b0, r_den}) begin
                    r_r <= rr - {1'b0, r_den};
                    r_q <= {r_q[NUMW-2:0], 1'b1};
                end else begin
                    r_r <= rr;
                    r_q <= {r_q[NUMW-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
        if (load) begin
            r_steer <= r_held_y[CW-1] ? -$signed({1'b0, mc}) : $signed({1'b0, mc});
            r_tidx  <= r_held_idx;
            if (big || m15 > i_cfg.gentle_thr) begin
                r_speed <= (big || m15 > i_cfg.sharp_thr) ? i_cfg.sharp_spd
                                                         : i_cfg.gentle_spd;
            end else begin
                r_speed <= i_cfg.straight_spd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best     <= '1;
            r_pbi      <= '0;
            r_pby      <= '0;
            r_found    <= 1'b0;
            r_held_idx <= '0;
            r_held_y   <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (o_pop && in_rng && in_idx == r_held_idx) begin
                r_held_y <= in_y;
            end
            if (r_state == S_DEV && dev < r_best) begin
                r_best  <= dev;
                r_pbi   <= r_idx;
                r_pby   <= r_y;
                r_found <= 1'b1;
            end
            if (r_state == S_END && r_found) begin
                r_held_idx <= r_pbi;
                r_held_y   <= r_pby;
            end
            if (load) begin
                r_ovalid <= 1'b1;
                r_best   <= '1;
                r_pbi    <= '0;
                r_pby    <= '0;
                r_found  <= 1'b0;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    `PPTS_ASSERT_NEXT(a_root_done, r_state == S_ROOT && r_cnt == DCW'(1), r_state == S_DEV)
    `PPTS_ASSERT_NEXT(a_pass_clear, load, !r_found && r_best == '1 && r_ovalid)
    `PPTS_ASSERT_NEXT(a_fin_hold, r_state == S_FIN && r_ovalid && !o_res.ready,
                      r_state == S_FIN)
    `PPTS_ASSERT_NOW(a_pop_idle, o_pop, r_state == S_IDLE && i_valid)
endmodule

// ===== rtl/core/pure_pursuit_target_steer.sv =====
`timescale 1ns / 1ps
// channel  dir  payload                                      transfer
// i_pt     in   point_x, point_y, last_point                 valid && ready
// o_res    out  steer_cmd, drive_speed, target_index         valid && ready
// apb      in   psel, penable, pwrite, paddr, pwdata         psel && penable && pwrite
//
// a waypoint with x < 0 is popped without a distance step in the back end, a candidate
// goes through the squares, then a one-bit-per-cycle square root
// the last point of a pass adds the bit-serial divide
// a two-entry queue decouples input acceptance from the back end
// synchronous active-low reset, no clearing pass; the back end holds a finished
// result until the output transfer and stalls on a full output register
module pure_pursuit_target_steer #(
    parameter int MAX_POINTS  = 4096,
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppts_in_if.sink     i_pt,
    ppts_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ppts_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int W  = 3 + IW + 2 * COORD_WIDTH;

    t_cfg         r_cfg;
    t_reg_idx     ridx;
    logic         f_push;
    logic [W-1:0] f_wdata;
    logic         f_full;
    logic         f_valid;
    logic [W-1:0] f_rdata;
    logic         f_pop;

    assign pready = 1'b1;
    assign ridx   = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lookahead    <= 16'd4096;
            r_cfg.gentle_thr   <= 15'd410;
            r_cfg.sharp_thr    <= 15'd819;
            r_cfg.steer_lim    <= 15'd1638;
            r_cfg.straight_spd <= 16'd16384;
            r_cfg.gentle_spd   <= 16'd14336;
            r_cfg.sharp_spd    <= 16'd10240;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                REG_LOOKAHEAD:    r_cfg.lookahead    <= pwdata[15:0];
                REG_GENTLE_THR:   r_cfg.gentle_thr   <= pwdata[14:0];
                REG_SHARP_THR:    r_cfg.sharp_thr    <= pwdata[14:0];
                REG_STEER_LIM:    r_cfg.steer_lim    <= pwdata[14:0];
                REG_STRAIGHT_SPD: r_cfg.straight_spd <= pwdata[15:0];
                REG_GENTLE_SPD:   r_cfg.gentle_spd   <= pwdata[15:0];
                REG_SHARP_SPD:    r_cfg.sharp_spd    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_LOOKAHEAD:    prdata = 32'(r_cfg.lookahead);
            REG_GENTLE_THR:   prdata = 32'(r_cfg.gentle_thr);
            REG_SHARP_THR:    prdata = 32'(r_cfg.sharp_thr);
            REG_STEER_LIM:    prdata = 32'(r_cfg.steer_lim);
            REG_STRAIGHT_SPD: prdata = 32'(r_cfg.straight_spd);
            REG_GENTLE_SPD:   prdata = 32'(r_cfg.gentle_spd);
            REG_SHARP_SPD:    prdata = 32'(r_cfg.sharp_spd);
            default:          prdata = '0;
        endcase
    end

    ppts_front #(
        .MAX_POINTS(MAX_POINTS),
        .CW        (COORD_WIDTH),
        .IW        (IW),
        .W         (W)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (i_pt),
        .i_full (f_full),
        .o_push (f_push),
        .o_data (f_wdata)
    );

    ppts_fifo #(
        .W(W)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_data (f_wdata),
        .i_pop  (f_pop),
        .o_full (f_full),
        .o_valid(f_valid),
        .o_data (f_rdata)
    );

    ppts_back #(
        .CW(COORD_WIDTH),
        .IW(IW),
        .FB(FRAC_BITS),
        .W (W)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_valid(f_valid),
        .i_data (f_rdata),
        .o_pop  (f_pop),
        .o_res  (o_res)
    );
endmodule

// ===== verif/pure_pursuit_target_steer_tb.sv =====
`timescale 1ns / 1ps
module pure_pursuit_target_steer_tb;
    import ppts_pkg::*;

    localparam int NPTS = 4096;
    localparam int FB   = 12;

    typedef struct {
        logic [15:0] steer;
        logic [15:0] speed;
        logic [11:0] index;
    } t_cmd;

    class steer_scoreboard;
        t_cfg        cfg;
        int unsigned pt_count;
        logic [24:0] best_dev;
        logic [11:0] best_idx;
        longint      best_y;
        bit          found;
        logic [11:0] held_idx;
        longint      held_y;
        t_cmd        cmd_q[$];
        int          errors;

        function void reset_state();
            cfg = '{16'd4096, 15'd410, 15'd819, 15'd1638, 16'd16384, 16'd14336, 16'd10240};
            held_idx = '0;
            held_y   = 0;
            cmd_q.delete();
            errors = 0;
            clear_pass();
        endfunction

        function void clear_pass();
            pt_count = 0;
            best_dev = '1;
            best_idx = '0;
            best_y   = 0;
            found    = 0;
        endfunction

        function void set_reg(t_reg_idx r, logic [31:0] v);
            case (r)
                REG_LOOKAHEAD:    cfg.lookahead    = v[15:0];
                REG_GENTLE_THR:   cfg.gentle_thr   = v[14:0];
                REG_SHARP_THR:    cfg.sharp_thr    = v[14:0];
                REG_STEER_LIM:    cfg.steer_lim    = v[14:0];
                REG_STRAIGHT_SPD: cfg.straight_spd = v[15:0];
                REG_GENTLE_SPD:   cfg.gentle_spd   = v[15:0];
                REG_SHARP_SPD:    cfg.sharp_spd    = v[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned floor_root(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_input(logic signed [23:0] px, logic signed [23:0] py, logic lst);
            longint          x;
            longint          y;
            longint unsigned d;
            longint unsigned dev;
            longint unsigned ym;
            longint unsigned m;
            longint unsigned la;
            t_cmd            c;
            x  = px;
            y  = py;
            la = cfg.lookahead;
            if (pt_count < NPTS) begin
                if (pt_count == held_idx) held_y = y;
                if (x >= 0) begin
                    d   = floor_root(x * x + y * y);
                    dev = (d >= la) ? d - la : la - d;
                    if (dev < best_dev) begin
                        best_dev = dev[24:0];
                        best_idx = pt_count[11:0];
                        best_y   = y;
                        found    = 1;
                    end
                end
                pt_count++;
            end
            if (!lst) return;
            if (found) begin
                held_idx = best_idx;
                held_y   = best_y;
            end
            ym = (held_y < 0) ? -held_y : held_y;
            if (ym == 0) m = 0;
            else if (la == 0) m = '1;
            else m = ((ym << 1) << (2 * FB)) / (la * la);
            if (m > cfg.gentle_thr)
                c.speed = (m > cfg.sharp_thr) ? cfg.sharp_spd : cfg.gentle_spd;
            else
                c.speed = cfg.straight_spd;
            if (m > cfg.steer_lim) m = cfg.steer_lim;
            c.steer = (held_y < 0) ? 16'(-m) : 16'(m);
            c.index = held_idx;
            cmd_q.insert(cmd_q.size(), c);
            clear_pass();
        endfunction

        function void check_result(logic [15:0] s, logic [15:0] v, logic [11:0] i);
            t_cmd c;
            if (cmd_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result steer=%0d speed=%0d idx=%0d",
                                           $signed(s), v, i);
                return;
            end
            c = cmd_q.pop_front();
            if (c.steer !== s || c.speed !== v || c.index !== i) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp steer=%0d speed=%0d idx=%0d, got %0d %0d %0d",
                             $signed(c.steer), c.speed, c.index, $signed(s), v, i);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    ppts_in_if  #(.CW(24)) pt_if();
    ppts_out_if #(.IW(12)) res_if();

    pure_pursuit_target_steer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_if.sink), .o_res(res_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    steer_scoreboard sb;
    int items_sent;
    int rdy_hold;
    int burst;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rdy_hold <= 0;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if ($urandom_range(0, 19) == 0) begin
            res_if.ready <= 1'b1;
            rdy_hold <= $urandom_range(50, 150);
        end else begin
            res_if.ready <= 1'($urandom_range(0, 1));
            rdy_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.steer_cmd, res_if.drive_speed, res_if.target_index);
    end

    function int pick_gap();
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if ($urandom_range(0, 14) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task send_pt(input logic signed [23:0] x, input logic signed [23:0] y, input logic lst,
                 input bit no_gap = 0);
        int g;
        pt_if.valid      <= 1'b1;
        pt_if.point_x    <= x;
        pt_if.point_y    <= y;
        pt_if.last_point <= lst;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        sb.note_input(x, y, lst);
        items_sent++;
        g = no_gap ? 0 : pick_gap();
        if (g > 0) begin
            pt_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task drain();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.cmd_q.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task reg_write(input t_reg_idx r, input logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(r, v);
        @(posedge i_clk);
    endtask

    task random_pass(input int len);
        int          k;
        int unsigned r;
        logic signed [23:0] x, y;
        for (int n = 0; n < len; n++) begin
            k = $urandom_range(0, 9);
            r = sb.cfg.lookahead + $urandom_range(0, 2000);
            if (r > 24'h7FFFFF) r = 24'h7FFFFF;
            if (k == 0) begin
                x = 24'($urandom);
                y = 24'($urandom);
            end else if (k == 1) begin
                x = -$signed({1'b0, 23'($urandom_range(1, 8388607))});
                y = 24'($urandom);
            end else begin
                x = 24'($urandom_range(0, r));
                y = 24'($urandom_range(0, r));
                if ($urandom_range(0, 1)) y = -y;
            end
            send_pt(x, y, n == len - 1);
        end
    endtask

    task random_config(input int mode);
        logic [31:0] v[7];
        for (int j = 0; j < 7; j++) v[j] = $urandom;
        case (mode)
            0: begin v[0] = 0; v[1] = 0; v[2] = 0; v[3] = 0; end
            1: begin v[0] = 16'hFFFF; v[1] = 15'h7FFF; v[2] = 15'h7FFF; v[3] = 15'h7FFF; end
            2: begin v[0] = 1; v[3] = 15'h7FFF; v[4] = 0; v[5] = 16'hFFFF; end
            default: begin
                v[0] = $urandom_range(1, 20000);
                v[1] = $urandom_range(0, 3000);
                v[2] = $urandom_range(0, 3000);
                v[3] = $urandom_range(0, 4000);
            end
        endcase
        for (int j = 0; j < 7; j++) reg_write(t_reg_idx'(j), v[j]);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        items_sent = 0;
        burst = 0;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        pt_if.valid = 0; pt_if.point_x = '0; pt_if.point_y = '0; pt_if.last_point = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, ties, behind points, held waypoint
        send_pt(24'sd0, 24'sd0, 1'b1);
        send_pt(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_pt(24'sh800000, 24'sh7FFFFF, 1'b0);
        send_pt(24'sd4096, 24'sd0, 1'b0);
        send_pt(24'sd0, 24'sd4096, 1'b1);
        send_pt(24'sd4000, -24'sd1000, 1'b0);
        send_pt(24'sd4000, 24'sd1000, 1'b0);
        send_pt(-24'sd1, 24'sd500, 1'b1);
        send_pt(-24'sd5, 24'sd700, 1'b0);
        send_pt(-24'sd5, -24'sd900, 1'b1);
        send_pt(-24'sd5, 24'sd123, 1'b1);
        send_pt(24'sd100, -24'sd4096, 1'b1);
        send_pt(24'sd3000, -24'sd2000, 1'b1);
        drain();
        random_config(0);
        send_pt(24'sd10, 24'sd5, 1'b1);
        send_pt(24'sd10, -24'sd5, 1'b1);
        send_pt(24'sd10, 24'sd0, 1'b1);
        drain();
        random_config(1);
        send_pt(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        send_pt(24'sd20000, 24'sh800000, 1'b1);
        drain();

        for (int ph = 0; items_sent < 530; ph++) begin
            random_config(ph % 6);
            for (int p = 0; p < 15; p++) random_pass($urandom_range(1, 8));
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ppts_pkg.sv
rtl/core/ppts_if.sv
rtl/core/ppts_front.sv
rtl/core/ppts_fifo.sv
rtl/core/ppts_back.sv
rtl/core/pure_pursuit_target_steer.sv
verif/pure_pursuit_target_steer_tb.sv
